### src/tcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_pkg: shared types and constants of the transposition cipher unit
// payload types, status and register codes, key nibble lookup
// ----------------------------------------------------------------------------
package tcu_pkg;

  localparam int ADDR_W    = 4;  // covers block buffers of up to 16 bytes
  localparam int KEY_NIBS  = 8;  // key nibbles held in the key register

  localparam logic [7:0] PAD_CHAR   = 8'h58;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_KEY = 2'd1;
  localparam logic [1:0] ST_PARTIAL = 2'd2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_KEY_LEN = 2'd1;
  localparam logic [1:0] REG_KEY_POS = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } text_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_byte;
    logic       end_of_block;
    logic       end_of_message;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic              buf_we;
    logic [ADDR_W-1:0] buf_waddr;
    logic [7:0]        buf_wdata;
    logic [ADDR_W-1:0] buf_raddr;
    logic              pl_clear;
    logic              pl_we;
    logic [ADDR_W-1:0] pl_waddr;
    logic [7:0]        pl_wdata;
    logic [ADDR_W-1:0] pl_raddr;
  } store_ctl_t;

  // zero-based key entry j (a one-based position), entries past the register read as zero
  function automatic logic [3:0] key_at(logic [31:0] keys, logic [4:0] j);
    logic [3:0] k;
    k = 4'd0;
    if (j < 5'(KEY_NIBS)) begin
      k = keys[{j[2:0], 2'b00} +: 4];
    end
    return k;
  endfunction

endpackage

### src/tcu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_if: valid/ready stream channel
// carries one payload request per handshake
// ----------------------------------------------------------------------------
interface tcu_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/tcu_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_store: block buffer and decrypt scatter buffer
// one write and one read port each, scatter entries not written read as space
// ----------------------------------------------------------------------------
module tcu_store
  import tcu_pkg::*;
#(
  parameter int MAX_KEY_LEN = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  store_ctl_t ctl,
  output logic [7:0] buf_rdata,
  output logic [7:0] pl_rdata
);

  localparam int IW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic [7:0]             buf_mem   [MAX_KEY_LEN];
  logic [7:0]             plain_mem [MAX_KEY_LEN];
  logic [MAX_KEY_LEN-1:0] pl_valid;

  always_ff @(posedge clk) begin
    if (ctl.buf_we) begin
      buf_mem[ctl.buf_waddr[IW-1:0]] <= ctl.buf_wdata;
    end
    if (ctl.pl_we) begin
      plain_mem[ctl.pl_waddr[IW-1:0]] <= ctl.pl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_valid <= '0;
    end else if (ctl.pl_clear) begin
      pl_valid <= '0;
    end else if (ctl.pl_we) begin
      pl_valid[ctl.pl_waddr[IW-1:0]] <= 1'b1;
    end
  end

  assign buf_rdata = buf_mem[ctl.buf_raddr[IW-1:0]];
  assign pl_rdata  = pl_valid[ctl.pl_raddr[IW-1:0]] ? plain_mem[ctl.pl_raddr[IW-1:0]]
                                                     : SPACE_CHAR;

endmodule

### src/tcu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_seq: block sequencer with shared key lookup and compare unit
// collects bytes, checks the key, then, while the result slot is free, permutes one byte per cycle
// ----------------------------------------------------------------------------
module tcu_seq
  import tcu_pkg::*;
#(
  parameter int MAX_KEY_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cipher_mode,
  input  logic [3:0]  key_length,
  input  logic [31:0] key_positions,
  input  logic        text_valid,
  input  text_t       text_data,
  output logic        text_ready,
  input  logic        slot_free,
  output logic        emit_valid,
  output result_t     emit_data,
  output store_ctl_t  ctl,
  input  logic [7:0]  buf_rdata,
  input  logic [7:0]  pl_rdata
);

  localparam int CW = $clog2(MAX_KEY_LEN + 1);
  localparam int IW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_MARK    = 3'd2;
  localparam logic [2:0] S_ENC     = 3'd3;
  localparam logic [2:0] S_SCAT    = 3'd4;
  localparam logic [2:0] S_TRIM0   = 3'd5;
  localparam logic [2:0] S_TRIM    = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] step;
  logic [CW-1:0] count_r;
  logic [CW-1:0] len_r;
  logic          last_r;
  logic [1:0]    status_r;
  logic [7:0]    cur_r;
  logic [7:0]    prior_r;

  logic [CW-1:0] m_eff;
  logic [CW-1:0] fill_inc;
  logic          blk_done;
  logic [3:0]    key_k;
  logic          key_bad;
  logic [IW-1:0] key_idx;
  logic          last_step;
  logic          emit_last;
  logic [7:0]    prev_byte;
  logic          text_fire;

  // block size after clamping to 1..MAX_KEY_LEN
  always_comb begin
    if (key_length == 4'd0) begin
      m_eff = CW'(1);
    end else if ({1'b0, key_length} > 5'(MAX_KEY_LEN)) begin
      m_eff = CW'(MAX_KEY_LEN);
    end else begin
      m_eff = CW'(key_length);
    end
  end

  assign text_ready = (state == S_COLLECT);
  assign text_fire  = text_valid && text_ready;
  assign fill_inc   = fill_count + CW'(1);
  assign blk_done   = (fill_inc >= m_eff) || text_data.last_byte;

  // shared key unit: entry lookup, range compare, zero-based position
  assign key_k     = key_at(key_positions, 5'(step));
  assign key_bad   = (key_k == 4'd0) || ({1'b0, key_k} > 5'(m_eff));
  assign key_idx   = IW'(key_k - 4'd1);
  assign last_step = (step == m_eff - CW'(1));
  assign emit_last = (step == len_r - CW'(1));
  assign prev_byte = (len_r >= CW'(2)) ? pl_rdata : prior_r;

  always_comb begin
    ctl           = '0;
    ctl.buf_we    = text_fire;
    ctl.buf_waddr = ADDR_W'(fill_count);
    ctl.buf_wdata = text_data.in_byte;
    ctl.buf_raddr = (state == S_ENC) ? ADDR_W'(key_idx) : ADDR_W'(step);
    ctl.pl_clear  = text_fire && blk_done;
    ctl.pl_we     = (state == S_SCAT);
    ctl.pl_waddr  = ADDR_W'(key_idx);
    ctl.pl_wdata  = buf_rdata;
    if (state == S_TRIM0) begin
      ctl.pl_raddr = ADDR_W'(m_eff - CW'(1));
    end else if (state == S_TRIM) begin
      ctl.pl_raddr = ADDR_W'(len_r - CW'(2));
    end else begin
      ctl.pl_raddr = ADDR_W'(step);
    end
  end

  always_comb begin
    emit_valid = 1'b0;
    emit_data  = '0;
    unique case (state)
      S_MARK: begin
        emit_valid                = 1'b1;
        emit_data.end_of_block    = 1'b1;
        emit_data.end_of_message  = last_r;
        emit_data.status          = status_r;
      end
      S_ENC: begin
        emit_valid                = 1'b1;
        emit_data.out_byte        = (5'(key_idx) >= 5'(count_r)) ? PAD_CHAR : buf_rdata;
        emit_data.carries_byte    = 1'b1;
        emit_data.end_of_block    = last_step;
        emit_data.end_of_message  = last_r && last_step;
        emit_data.status          = ST_OK;
      end
      S_EMIT: begin
        emit_valid                = 1'b1;
        emit_data.out_byte        = pl_rdata;
        emit_data.carries_byte    = 1'b1;
        emit_data.end_of_block    = emit_last;
        emit_data.end_of_message  = last_r && emit_last;
        emit_data.status          = ST_OK;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      fill_count <= '0;
      step       <= '0;
      count_r    <= '0;
      len_r      <= '0;
      last_r     <= 1'b0;
      status_r   <= ST_OK;
      cur_r      <= '0;
      prior_r    <= '0;
    end else begin
      unique case (state)
        S_COLLECT: begin
          if (text_valid) begin
            if (blk_done) begin
              fill_count <= '0;
              count_r    <= (fill_inc < m_eff) ? fill_inc : m_eff;
              last_r     <= text_data.last_byte;
              step       <= '0;
              state      <= S_CHECK;
            end else begin
              fill_count <= fill_inc;
            end
          end
        end
        S_CHECK: begin
          if (key_bad) begin
            status_r <= ST_BAD_KEY;
            state    <= S_MARK;
          end else if (last_step) begin
            step <= '0;
            if (cipher_mode == MODE_ENC) begin
              state <= S_ENC;
            end else if (count_r < m_eff) begin
              status_r <= ST_PARTIAL;
              state    <= S_MARK;
            end else begin
              state <= S_SCAT;
            end
          end else begin
            step <= step + CW'(1);
          end
        end
        S_MARK: begin
          if (slot_free) begin
            if (last_r) begin
              prior_r <= '0;
            end
            state <= S_COLLECT;
          end
        end
        S_ENC: begin
          if (slot_free) begin
            if (last_step) begin
              if (last_r) begin
                prior_r <= '0;
              end
              state <= S_COLLECT;
            end else begin
              step <= step + CW'(1);
            end
          end
        end
        S_SCAT: begin
          if (last_step) begin
            step  <= '0;
            len_r <= m_eff;
            state <= last_r ? S_TRIM0 : S_EMIT;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_TRIM0: begin
          cur_r <= pl_rdata;
          state <= S_TRIM;
        end
        S_TRIM: begin
          if ((cur_r == PAD_CHAR) && (prev_byte != SPACE_CHAR)) begin
            len_r <= len_r - CW'(1);
            cur_r <= prev_byte;
            if (len_r == CW'(1)) begin
              status_r <= ST_OK;
              state    <= S_MARK;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (emit_last) begin
              prior_r <= last_r ? 8'd0 : pl_rdata;
              state   <= S_COLLECT;
            end else begin
              step <= step + CW'(1);
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  a_no_emit_collect: assert property (@(posedge clk) disable iff (rst)
    state == S_COLLECT |-> !emit_valid)
    else $error("result offered while collecting");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < CW'(MAX_KEY_LEN))
    else $error("fill count past buffer depth");

  a_eom_to_collect: assert property (@(posedge clk) disable iff (rst)
    emit_valid && slot_free && emit_data.end_of_message |=> state == S_COLLECT)
    else $error("message end not followed by collect");

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    emit_valid && !emit_data.carries_byte |-> emit_data.out_byte == 8'd0 &&
    emit_data.end_of_block)
    else $error("malformed marker result");

  a_enc_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_ENC |-> 5'(key_idx) < 5'(m_eff))
    else $error("encrypt read outside block");

endmodule

### src/block_transposition_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_transposition_cipher_unit: byte stream block transposition cipher
// gathers a block (key_length bytes, clamped), then emits it permuted by the key
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              handshake
//  text     in   in_byte, last_byte                                   valid/ready
//  result   out  out_byte, carries_byte, end_of_block,                valid/ready
//                end_of_message, status
//  cfg      in   cfg_index, cfg_data                                  cfg_en strobe
//
//  a byte that does not close a block is only written to the block buffer
//  a closing byte runs the key check over the key entries; a bad key, or a short
//  block on decrypt, gives a status marker, else it emits the permuted results
//  for encrypt, or scatters the block, trims padding from a final block and then
//  emits the results for decrypt; these steps run one after another on the single
//  key lookup and compare unit and the one read port of each block buffer
//  text.ready is low from a closing byte until its last result is registered
//  a stall on result holds an offering sequencer; reset is synchronous, active high
// ----------------------------------------------------------------------------
module block_transposition_cipher_unit
  import tcu_pkg::*;
#(
  parameter int MAX_KEY_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  tcu_if.sink         text,
  tcu_if.source       result,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic        cipher_mode;
  logic [3:0]  key_length;
  logic [31:0] key_positions;

  // output register between sequencer and result channel
  logic        out_valid;
  result_t     out_data;
  logic        slot_free;

  logic        emit_valid;
  result_t     emit_data;
  store_ctl_t  ctl;
  logic [7:0]  buf_rdata;
  logic [7:0]  pl_rdata;
  logic        text_ready;

  // configuration writes must be made only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode   <= MODE_ENC;
      key_length    <= 4'd8;
      key_positions <= 32'h8765_4321;  // identity permutation
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_MODE:    cipher_mode   <= cfg_data[0];
        REG_KEY_LEN: key_length    <= cfg_data[3:0];
        REG_KEY_POS: key_positions <= cfg_data;
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

  // slot is free when empty or being taken this cycle
  assign slot_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && slot_free) begin
      out_data <= emit_data;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign text.ready   = text_ready;

  tcu_seq #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cipher_mode   (cipher_mode),
    .key_length    (key_length),
    .key_positions (key_positions),
    .text_valid    (text.valid),
    .text_data     (text.data),
    .text_ready    (text_ready),
    .slot_free     (slot_free),
    .emit_valid    (emit_valid),
    .emit_data     (emit_data),
    .ctl           (ctl),
    .buf_rdata     (buf_rdata),
    .pl_rdata      (pl_rdata)
  );

  // block buffer plus decrypt scatter buffer
  tcu_store #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .buf_rdata (buf_rdata),
    .pl_rdata  (pl_rdata)
  );

endmodule
